// File: design/mdc_pkg.sv
// mdc_pkg: shared constants, codes and controller/datapath interface types
// for the multi-car elevator dispatcher; no dependencies
`timescale 1ns / 1ps

package mdc_pkg;

    // building size
    localparam int NUM_CARS   = 4;
    localparam int NUM_FLOORS = 16;

    // internal widths
    localparam int CAR_W = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
    localparam int FL_W  = $clog2(NUM_FLOORS);

    // port field widths
    localparam int KIND_W = 2;
    localparam int FLD_W  = 4;
    localparam int IDX_W  = 4;
    localparam int HEAD_W = 2;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_HALL = 2'd1,
        KIND_CAR  = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    // car headings
    typedef enum logic [HEAD_W-1:0] {
        HEAD_UP   = 2'd0,
        HEAD_DOWN = 2'd1,
        HEAD_IDLE = 2'd2
    } t_heading;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_APPLY,
        ST_REJECT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             tick_step;
        logic             scan_step;
        logic             scan_first;
        logic             apply;
        logic             reject;
        logic             last;
        logic [CAR_W-1:0] car;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  floor_bad;
        logic  car_bad;
        logic  out_free;
    } t_dp_stat;

    // updated pending mask and heading of one car
    typedef struct packed {
        logic [NUM_FLOORS-1:0] pend;
        t_heading              head;
    } t_car_next;

endpackage

// File: design/mdc_ctrl.sv
// mdc_ctrl: request sequencer; decodes each accepted request and steps the
// car counter through ticks and hall scans. depends on mdc_pkg
`timescale 1ns / 1ps

module mdc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mdc_pkg::t_dp_stat i_stat,
    output mdc_pkg::t_dp_cmd  o_cmd
);
    import mdc_pkg::*;

    localparam logic [CAR_W-1:0] LAST_CAR = CAR_W'(NUM_CARS - 1);

    t_state           r_state, n_state;
    logic [CAR_W-1:0] r_car, n_car;
    logic             last_car;

    assign last_car = (r_car == LAST_CAR);

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_car   <= '0;
        end else begin
            r_state <= n_state;
            r_car   <= n_car;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_stat.kind)
                        KIND_TICK: n_state = ST_TICK;
                        KIND_HALL: n_state = i_stat.floor_bad ? ST_REJECT : ST_SCAN;
                        KIND_CAR:  n_state = (i_stat.floor_bad || i_stat.car_bad)
                                             ? ST_REJECT : ST_APPLY;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TICK: begin
                if (i_stat.out_free && last_car) n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (last_car) n_state = ST_APPLY;
            end
            ST_APPLY, ST_REJECT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // car counter
    always_comb begin
        n_car = r_car;
        unique case (r_state)
            ST_IDLE: n_car = '0;
            ST_TICK: begin
                if (i_stat.out_free) n_car = last_car ? '0 : r_car + CAR_W'(1);
            end
            ST_SCAN: n_car = last_car ? '0 : r_car + CAR_W'(1);
            default: n_car = r_car;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready       = (r_state == ST_IDLE);
        o_cmd.load       = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.tick_step  = (r_state == ST_TICK) && i_stat.out_free;
        o_cmd.scan_step  = (r_state == ST_SCAN);
        o_cmd.scan_first = (r_car == '0);
        o_cmd.apply      = (r_state == ST_APPLY) && i_stat.out_free;
        o_cmd.reject     = (r_state == ST_REJECT) && i_stat.out_free;
        o_cmd.last       = last_car;
        o_cmd.car        = r_car;
    end

    // a result is only written into a free output slot
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.tick_step || o_cmd.apply || o_cmd.reject) |-> i_stat.out_free)
        else $error("result written while output slot busy");

    // a tick starts from car zero
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_stat.kind == KIND_TICK) |=> (r_state == ST_TICK && r_car == '0))
        else $error("tick did not start at car zero");

    // a hall scan always ends in the apply step
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && last_car) |=> (r_state == ST_APPLY))
        else $error("hall scan did not reach apply");

    // a tick step that is not the last keeps ticking
    a_tick_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.tick_step && !last_car) |=> (r_state == ST_TICK))
        else $error("tick ended before the last car");

endmodule

// File: design/mdc_dp.sv
// mdc_dp: car state registers, move/heading logic, nearest-car compare and
// the output register. depends on mdc_pkg
`timescale 1ns / 1ps

module mdc_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mdc_pkg::KIND_W-1:0] i_kind,
    input  logic [mdc_pkg::FLD_W-1:0]  i_target_floor,
    input  logic [mdc_pkg::FLD_W-1:0]  i_car_select,
    input  mdc_pkg::t_dp_cmd           i_cmd,
    output mdc_pkg::t_dp_stat          o_stat,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [mdc_pkg::IDX_W-1:0]  o_car_index,
    output logic [mdc_pkg::FLD_W-1:0]  o_car_floor,
    output logic [mdc_pkg::HEAD_W-1:0] o_car_heading,
    output logic                       o_accepted,
    output logic                       o_last_of_run
);
    import mdc_pkg::*;

    // settle heading and clear the current floor while it lies at the low edge
    function automatic t_car_next recompute(input logic [NUM_FLOORS-1:0] m,
                                            input logic [FL_W-1:0] f,
                                            input t_heading h);
        logic [NUM_FLOORS-1:0] above;
        logic [NUM_FLOORS-1:0] below;
        t_car_next             res;
        for (int i = 0; i < NUM_FLOORS; i++) begin
            above[i] = m[i] && ((FL_W + 1)'(i) > {1'b0, f});
            below[i] = m[i] && ((FL_W + 1)'(i) < {1'b0, f});
        end
        res.pend = m;
        res.head = h;
        if (below == '0) begin
            res.pend = m & ~(NUM_FLOORS'(1) << f);
            res.head = (above != '0) ? HEAD_UP : HEAD_IDLE;
        end else if (above == '0 && !m[f]) begin
            res.head = HEAD_DOWN;
        end
        return res;
    endfunction

    // car state
    logic [FL_W-1:0]       r_floor [NUM_CARS];
    t_heading              r_head  [NUM_CARS];
    logic [NUM_FLOORS-1:0] r_pend  [NUM_CARS];

    // latched request
    t_kind            r_kind;
    logic [FL_W-1:0]  r_tf;
    logic [FLD_W-1:0] r_cs;

    // best car of the hall scan
    logic [CAR_W-1:0] r_best;
    logic [FL_W-1:0]  r_best_d;
    logic             r_best_idle;

    // output register
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_o_idx;
    logic [FL_W-1:0]   r_o_floor;
    t_heading          r_o_head;
    logic              r_o_acc;
    logic              r_o_last;

    logic             emit;
    logic [CAR_W-1:0] sel_car;
    logic [FL_W-1:0]  cur_floor;
    t_heading         cur_head;
    logic [NUM_FLOORS-1:0] cur_pend;
    logic [FL_W-1:0]  mv_floor;
    t_car_next        mv_next;
    t_car_next        add_next;
    logic [FL_W-1:0]  hall_dist;
    logic             cand_idle;
    logic             better;

    // status toward the controller, taken from the waiting request
    assign o_stat.kind      = t_kind'(i_kind);
    assign o_stat.floor_bad = ({1'b0, i_target_floor} >= (FLD_W + 1)'(NUM_FLOORS));
    assign o_stat.car_bad   = ({1'b0, i_car_select} >= (FLD_W + 1)'(NUM_CARS));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign emit = i_cmd.tick_step || i_cmd.apply || i_cmd.reject;

    // car under work: counter for tick and scan, chosen car for apply
    always_comb begin
        if (i_cmd.apply) begin
            sel_car = (r_kind == KIND_HALL) ? r_best : r_cs[CAR_W-1:0];
        end else begin
            sel_car = i_cmd.car;
        end
    end

    assign cur_floor = r_floor[sel_car];
    assign cur_head  = r_head[sel_car];
    assign cur_pend  = r_pend[sel_car];

    // one-floor move for a tick
    always_comb begin
        mv_floor = cur_floor;
        case (cur_head)
            HEAD_UP:   if (cur_floor != FL_W'(NUM_FLOORS - 1)) mv_floor = cur_floor + FL_W'(1);
            HEAD_DOWN: if (cur_floor != '0) mv_floor = cur_floor - FL_W'(1);
            default:   mv_floor = cur_floor;
        endcase
        if (cur_pend == '0) begin
            mv_next.pend = cur_pend;
            mv_next.head = HEAD_IDLE;
        end else begin
            mv_next = recompute(cur_pend & ~(NUM_FLOORS'(1) << mv_floor), mv_floor, cur_head);
        end
    end

    // new destination for a hall or car request
    assign add_next = recompute(cur_pend | (NUM_FLOORS'(1) << r_tf), cur_floor, cur_head);

    // distance and ranking for the hall scan: idle first, then nearest
    assign hall_dist = (cur_floor > r_tf) ? (cur_floor - r_tf) : (r_tf - cur_floor);
    assign cand_idle = (cur_head == HEAD_IDLE);
    assign better    = i_cmd.scan_first
                    || (cand_idle && !r_best_idle)
                    || ((cand_idle == r_best_idle) && (hall_dist < r_best_d));

    // car state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CARS; c++) begin
                r_floor[c] <= '0;
                r_head[c]  <= HEAD_IDLE;
                r_pend[c]  <= '0;
            end
        end else if (i_cmd.tick_step) begin
            r_floor[sel_car] <= mv_floor;
            r_head[sel_car]  <= mv_next.head;
            r_pend[sel_car]  <= mv_next.pend;
        end else if (i_cmd.apply) begin
            r_head[sel_car]  <= add_next.head;
            r_pend[sel_car]  <= add_next.pend;
        end
    end

    // request latch and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_kind'(i_kind);
            r_tf   <= i_target_floor[FL_W-1:0];
            r_cs   <= i_car_select;
        end
        if (i_cmd.scan_step && better) begin
            r_best      <= sel_car;
            r_best_d    <= hall_dist;
            r_best_idle <= cand_idle;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_step) begin
            r_o_idx   <= IDX_W'(sel_car);
            r_o_floor <= mv_floor;
            r_o_head  <= mv_next.head;
            r_o_acc   <= 1'b1;
            r_o_last  <= i_cmd.last;
        end else if (i_cmd.apply) begin
            r_o_idx   <= IDX_W'(sel_car);
            r_o_floor <= cur_floor;
            r_o_head  <= add_next.head;
            r_o_acc   <= 1'b1;
            r_o_last  <= 1'b1;
        end else if (i_cmd.reject) begin
            r_o_idx   <= (r_kind == KIND_CAR) ? r_cs : '0;
            r_o_floor <= '0;
            r_o_head  <= HEAD_UP;
            r_o_acc   <= 1'b0;
            r_o_last  <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_car_index   = r_o_idx;
    assign o_car_floor   = FLD_W'(r_o_floor);
    assign o_car_heading = r_o_head;
    assign o_accepted    = r_o_acc;
    assign o_last_of_run = r_o_last;

    // every write of the output register shows up as a valid result
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_out_valid)
        else $error("written result not presented");

    // a pending result that is not taken is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !emit)
        else $error("pending result overwritten");

endmodule

// File: design/multi_car_elevator_dispatcher_top.sv
// multi_car_elevator_dispatcher_top: nearest-car elevator dispatcher,
// joins the sequencer (mdc_ctrl) and the car datapath (mdc_dp); uses mdc_pkg
//
//   channel   direction  handshake                  payload
//   request   in         i_in_valid / o_in_ready     i_kind, i_target_floor, i_car_select
//   result    out        o_out_valid / i_out_ready   o_car_index, o_car_floor,
//                                                    o_car_heading, o_accepted, o_last_of_run
//
// one request at a time: a tick visits every car in turn, one car moved and
// reported per cycle while the output slot is free; a hall request compares one car per cycle,
// then applies to the best car; a car request or a rejection takes one apply or reject step.
// each result waits in a single output register; a stalled result holds the
// next result back, but a new request is taken as soon as the last one is staged.
// synchronous active-low reset puts every car at floor zero, idle, no destinations.
`timescale 1ns / 1ps

module multi_car_elevator_dispatcher_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [mdc_pkg::KIND_W-1:0] i_kind,
    input  logic [mdc_pkg::FLD_W-1:0]  i_target_floor,
    input  logic [mdc_pkg::FLD_W-1:0]  i_car_select,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [mdc_pkg::IDX_W-1:0]  o_car_index,
    output logic [mdc_pkg::FLD_W-1:0]  o_car_floor,
    output logic [mdc_pkg::HEAD_W-1:0] o_car_heading,
    output logic                       o_accepted,
    output logic                       o_last_of_run
);
    import mdc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    mdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // car state and result datapath
    mdc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_kind),
        .i_target_floor (i_target_floor),
        .i_car_select   (i_car_select),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_car_index    (o_car_index),
        .o_car_floor    (o_car_floor),
        .o_car_heading  (o_car_heading),
        .o_accepted     (o_accepted),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
